### rtl/lgge_pkg.sv
package lgge_pkg;

    // grid bounds
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // derived widths
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W0  = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_W0 > CFG_W) ? DIM_W0 : CFG_W;
    localparam int CNT_W   = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_W   = (CNT_W > DIM_W) ? CNT_W : DIM_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd64;

    typedef logic [MAX_WIDTH-1:0] row_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [ROW_W-1:0] row;
    } mem_rd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [ROW_W-1:0] row;
        row_t             data;
    } mem_wr_t;

endpackage

### rtl/lgge_if.sv
interface lgge_item_if import lgge_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               write_alive;

    modport source (output valid, op, cell_x, cell_y, write_alive, input ready);
    modport sink (input valid, op, cell_x, cell_y, write_alive, output ready);
endinterface

interface lgge_result_if ();
    logic valid;
    logic ready;
    logic cell_alive;
    logic coord_error;

    modport source (output valid, cell_alive, coord_error, input ready);
    modport sink (input valid, cell_alive, coord_error, output ready);
endinterface

interface lgge_cfg_if import lgge_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/lgge_row_mem.sv
module lgge_row_mem import lgge_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  mem_rd_t rd,
    output row_t    rd_data,
    input  mem_wr_t wr,
    input  logic    clr_en,
    input  logic    clr_bank
);

    // two banks of row-wide storage, current grid and build buffer
    row_t mem [0:1][0:MAX_HEIGHT-1];

    logic [1:0][MAX_HEIGHT-1:0] valid_reg;
    row_t                       data_reg;
    logic                       hit_reg;

    // storage port, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.row] <= wr.data;
        end
        if (rd.en)
        begin
            data_reg <= mem[rd.bank][rd.row];
        end
    end

    // per-row valid bits, a row never written since clear reads as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (clr_en)
            begin
                valid_reg[clr_bank] <= '0;
            end
            if (wr.en)
            begin
                valid_reg[wr.bank][wr.row] <= 1'b1;
            end
            if (rd.en)
            begin
                hit_reg <= valid_reg[rd.bank][rd.row];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

### rtl/lgge_row_rule.sv
module lgge_row_rule import lgge_pkg::*; (
    input  row_t above,
    input  row_t center,
    input  row_t below,
    input  row_t col_mask,
    input  logic row_live,
    output row_t next_row
);

    logic [MAX_WIDTH+1:0] pad_a;
    logic [MAX_WIDTH+1:0] pad_c;
    logic [MAX_WIDTH+1:0] pad_b;
    logic [3:0]           cnt [MAX_WIDTH];
    row_t                 born;

    // dead border on both sides of each row
    assign pad_a = {1'b0, above, 1'b0};
    assign pad_c = {1'b0, center, 1'b0};
    assign pad_b = {1'b0, below, 1'b0};

    // neighbor count and b3/s23 rule for every column
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            cnt[i] = 4'(pad_a[i]) + 4'(pad_a[i+1]) + 4'(pad_a[i+2])
                   + 4'(pad_c[i]) + 4'(pad_c[i+2])
                   + 4'(pad_b[i]) + 4'(pad_b[i+1]) + 4'(pad_b[i+2]);
            if (center[i])
            begin
                born[i] = (cnt[i] == 4'd2) || (cnt[i] == 4'd3);
            end
            else
            begin
                born[i] = (cnt[i] == 4'd3);
            end
        end
    end

    assign next_row = row_live ? (born & col_mask) : '0;

endmodule

### rtl/life_grid_generation_engine.sv
// read and write cell pass through S_CELL and then S_DONE, clear and rejected access
// go straight to S_DONE, step runs through S_STEP and then S_DONE before result valid
// one request at a time; a step walks the grid one row per cycle through the
// row-wide memory port, so its throughput is set by MAX_HEIGHT
// reset: width and height 64, grid all dead at once via per-row valid bits,
// no clearing pass
module life_grid_generation_engine import lgge_pkg::*; (
    input logic           clk,
    input logic           rst_n,
    lgge_item_if.sink     item,
    lgge_result_if.source result,
    lgge_cfg_if.sink      cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             res_valid_reg, res_valid_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             wval_reg, wval_next;
    logic             alive_reg, alive_next;
    logic             err_reg, err_next;
    logic             res_alive_reg, res_alive_next;
    logic             res_err_reg, res_err_next;
    logic [CNT_W-1:0] pend_row_reg, pend_row_next;
    row_t             win_a_reg, win_a_next;
    row_t             win_b_reg, win_b_next;

    logic [DIM_W-1:0] act_w;
    logic [DIM_W-1:0] act_h;
    row_t             col_mask;
    row_t             rdata;
    row_t             row_in;
    row_t             rule_row;
    row_t             patched;
    logic [CNT_W-1:0] prev_row;
    logic             row_live;
    logic             coord_bad;
    mem_rd_t          rd;
    mem_wr_t          wr;
    logic             clr_en;

    // active size clipped to the grid bounds
    assign act_w = (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                             : DIM_W'(width_reg);
    assign act_h = (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                               : DIM_W'(height_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            col_mask[i] = CMP_W'(i) < CMP_W'(act_w);
        end
    end

    assign coord_bad = (CMP_W'(item.cell_x) >= CMP_W'(act_w))
                    || (CMP_W'(item.cell_y) >= CMP_W'(act_h));

    // row window feeding the rule
    assign row_in   = (CMP_W'(pend_row_reg) < CMP_W'(act_h)) ? (rdata & col_mask) : '0;
    assign prev_row = pend_row_reg - CNT_W'(1);
    assign row_live = CMP_W'(prev_row) < CMP_W'(act_h);

    always_comb
    begin
        patched          = rdata;
        patched[col_reg] = wval_reg;
    end

    lgge_row_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .rd_data  (rdata),
        .wr       (wr),
        .clr_en   (clr_en),
        .clr_bank (bank_reg)
    );

    lgge_row_rule u_rule (
        .above    (win_a_reg),
        .center   (win_b_reg),
        .below    (row_in),
        .col_mask (col_mask),
        .row_live (row_live),
        .next_row (rule_row)
    );

    // handshakes
    assign item.ready         = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = res_valid_reg;
    assign result.cell_alive  = res_alive_reg;
    assign result.coord_error = res_err_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        res_valid_next = res_valid_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wval_next      = wval_reg;
        alive_next     = alive_reg;
        err_next       = err_reg;
        res_alive_next = res_alive_reg;
        res_err_next   = res_err_reg;
        pend_row_next  = pend_row_reg;
        win_a_next     = win_a_reg;
        win_b_next     = win_b_reg;
        rd             = '0;
        wr             = '0;
        clr_en         = 1'b0;

        // config writes
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GRID_WIDTH:  width_next  = cfg.data;
                CFG_GRID_HEIGHT: height_next = cfg.data;
                default:         ;
            endcase
        end

        // result taken
        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    op_next    = item.op;
                    col_next   = COL_W'(item.cell_x);
                    row_next   = ROW_W'(item.cell_y);
                    wval_next  = item.write_alive;
                    alive_next = 1'b0;
                    err_next   = 1'b0;
                    unique case (item.op) inside
                        OP_WRITE, OP_READ:
                        begin
                            if (coord_bad)
                            begin
                                err_next   = 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd.en      = 1'b1;
                                rd.bank    = bank_reg;
                                rd.row     = ROW_W'(item.cell_y);
                                state_next = S_CELL;
                            end
                        end
                        OP_STEP:
                        begin
                            rd_cnt_next = '0;
                            pend_next   = 1'b0;
                            win_a_next  = '0;
                            win_b_next  = '0;
                            state_next  = S_STEP;
                        end
                        default:
                        begin
                            clr_en     = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                if (op_reg == OP_WRITE)
                begin
                    wr.en   = 1'b1;
                    wr.bank = bank_reg;
                    wr.row  = row_reg;
                    wr.data = patched;
                end
                else
                begin
                    alive_next = rdata[col_reg];
                end
                state_next = S_DONE;
            end
            S_STEP:
            begin
                // issue row reads, one past the last row for the trailing window
                if (CMP_W'(rd_cnt_reg) <= CMP_W'(MAX_HEIGHT))
                begin
                    rd.en         = (CMP_W'(rd_cnt_reg) < CMP_W'(MAX_HEIGHT));
                    rd.bank       = bank_reg;
                    rd.row        = ROW_W'(rd_cnt_reg);
                    pend_next     = 1'b1;
                    pend_row_next = rd_cnt_reg;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // returning row completes the window of the row above it
                if (pend_reg)
                begin
                    win_a_next = win_b_reg;
                    win_b_next = row_in;
                    if (pend_row_reg != '0)
                    begin
                        wr.en   = 1'b1;
                        wr.bank = ~bank_reg;
                        wr.row  = ROW_W'(prev_row);
                        wr.data = rule_row;
                    end
                    if (CMP_W'(pend_row_reg) == CMP_W'(MAX_HEIGHT))
                    begin
                        bank_next  = ~bank_reg;
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_alive_next = alive_reg;
                    res_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            width_reg     <= CFG_SIZE_RESET;
            height_reg    <= CFG_SIZE_RESET;
            res_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            res_valid_reg <= res_valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        wval_reg      <= wval_next;
        alive_reg     <= alive_next;
        err_reg       <= err_next;
        res_alive_reg <= res_alive_next;
        res_err_reg   <= res_err_next;
        pend_row_reg  <= pend_row_next;
        win_a_reg     <= win_a_next;
        win_b_reg     <= win_b_next;
    end

endmodule
